@@ rtl/crl_pkg.sv @@
// Shared types and constants for the connection rate limiter.
// No dependencies; every other file of the block but crl_ram imports this package.
`default_nettype none

package crl_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam int ADDR_W  = 32;
    localparam int TIME_W  = 48;
    localparam int COUNT_W = 16;
    localparam int CFG_W   = 20;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PER_WINDOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_MS       = 2'd2;

    localparam logic [15:0] WINDOW_MS_RESET      = 16'd1000;
    localparam logic [15:0] MAX_PER_WINDOW_RESET = 16'd10;
    localparam logic [19:0] BLOCK_MS_RESET       = 20'd10000;

    typedef enum logic [2:0] {
        VC_KNOWN_OK = 3'd0,
        VC_NEW      = 3'd1,
        VC_ZERO     = 3'd2,
        VC_BLOCKED  = 3'd3,
        VC_RATE     = 3'd4
    } t_verdict;

    // Outcome of the table lookup for one request.
    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_FULL,
        KIND_NEW,
        KIND_KNOWN
    } t_kind;

    typedef struct packed {
        logic [ADDR_W-1:0] source_address;
        logic [TIME_W-1:0] now_ms;
    } t_req;

    typedef struct packed {
        logic     accepted;
        t_verdict verdict_code;
        logic     table_full;
    } t_rsp;

    typedef struct packed {
        logic [15:0] window_ms;
        logic [15:0] max_per_window;
        logic [19:0] block_ms;
    } t_cfg;

    typedef struct packed {
        t_kind            kind;
        logic [IDX_W-1:0] idx;
    } t_lookup;

    typedef struct packed {
        logic [TIME_W-1:0]  window_start;
        logic [TIME_W-1:0]  block_until;
        logic [COUNT_W-1:0] attempt_count;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

@@ rtl/crl_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; read during a write to the same address returns old data.
`default_nettype none

module crl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                                          i_clk,
    input  wire                                          i_we,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]                              i_wdata,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/crl_cam.sv @@
// Address table: valid bits and source addresses in flip-flops, compared in
// parallel; allocates the lowest free entry for a new source. Uses crl_pkg.
`default_nettype none

module crl_cam (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    input  wire [crl_pkg::ADDR_W-1:0]    i_addr,
    output crl_pkg::t_lookup             o_lookup
);
    import crl_pkg::*;

    logic              r_valid [TABLE_ENTRIES];
    logic [ADDR_W-1:0] r_addr  [TABLE_ENTRIES];

    logic             any_hit;
    logic             any_free;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] free_idx;
    logic             alloc;

    // Addresses are unique among valid entries, so at most one entry hits.
    always_comb begin
        any_hit  = 1'b0;
        any_free = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_addr[i] == i_addr)) begin
                any_hit = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                any_free = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        o_lookup.idx = hit_idx;
        alloc        = 1'b0;
        priority if (i_addr == '0) begin
            o_lookup.kind = KIND_ZERO;
        end else if (any_hit) begin
            o_lookup.kind = KIND_KNOWN;
        end else if (any_free) begin
            o_lookup.kind = KIND_NEW;
            o_lookup.idx  = free_idx;
            alloc         = i_valid;
        end else begin
            o_lookup.kind = KIND_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (alloc) begin
            r_valid[free_idx] <= 1'b1;
        end
        if (alloc) begin
            r_addr[free_idx] <= i_addr;
        end
    end

endmodule

`default_nettype wire

@@ rtl/crl_update.sv @@
// Per-source window and block evaluation: computes the verdict and the
// updated entry for one request. Combinational; uses crl_pkg.
`default_nettype none

module crl_update (
    input  crl_pkg::t_kind               i_kind,
    input  wire [crl_pkg::TIME_W-1:0]    i_now,
    input  crl_pkg::t_entry              i_entry,
    input  crl_pkg::t_cfg                i_cfg,
    output logic                         o_we,
    output crl_pkg::t_entry              o_entry,
    output crl_pkg::t_rsp                o_rsp
);
    import crl_pkg::*;

    logic [COUNT_W-1:0] count_inc;
    logic               blocked;
    logic [TIME_W-1:0]  elapsed;
    logic               window_over;
    logic               over_limit;
    logic [TIME_W:0]    end_sum;
    logic [TIME_W-1:0]  block_end;

    always_comb begin
        count_inc   = (i_entry.attempt_count == '1) ? i_entry.attempt_count
                                                    : i_entry.attempt_count + 1'b1;
        blocked     = i_entry.block_until > i_now;
        elapsed     = i_now - i_entry.window_start;
        window_over = elapsed > {{(TIME_W - 16){1'b0}}, i_cfg.window_ms};
        // The sampled count is the one after this attempt has been counted.
        over_limit  = count_inc > i_cfg.max_per_window;
        end_sum     = {1'b0, i_now} + {{(TIME_W + 1 - 20){1'b0}}, i_cfg.block_ms};
        block_end   = end_sum[TIME_W] ? '1 : end_sum[TIME_W-1:0];
    end

    always_comb begin
        o_we    = 1'b0;
        o_entry = i_entry;
        o_rsp   = '{accepted: 1'b1, verdict_code: VC_KNOWN_OK, table_full: 1'b0};
        unique case (i_kind)
            KIND_ZERO: begin
                o_rsp = '{accepted: 1'b0, verdict_code: VC_ZERO, table_full: 1'b0};
            end
            KIND_FULL: begin
                o_rsp = '{accepted: 1'b1, verdict_code: VC_NEW, table_full: 1'b1};
            end
            KIND_NEW: begin
                o_we                  = 1'b1;
                o_entry.window_start  = i_now;
                o_entry.block_until   = '0;
                o_entry.attempt_count = COUNT_W'(1);
                o_rsp = '{accepted: 1'b1, verdict_code: VC_NEW, table_full: 1'b0};
            end
            KIND_KNOWN: begin
                o_we                  = 1'b1;
                o_entry.attempt_count = count_inc;
                priority if (blocked) begin
                    o_rsp = '{accepted: 1'b0, verdict_code: VC_BLOCKED,
                              table_full: 1'b0};
                end else if (window_over) begin
                    o_entry.window_start  = i_now;
                    o_entry.attempt_count = '0;
                    o_entry.block_until   = over_limit ? block_end : '0;
                    if (over_limit) begin
                        o_rsp = '{accepted: 1'b0, verdict_code: VC_RATE,
                                  table_full: 1'b0};
                    end
                end else begin
                    o_rsp = '{accepted: 1'b1, verdict_code: VC_KNOWN_OK,
                              table_full: 1'b0};
                end
            end
            default: begin
                o_we = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/connection_rate_limiter.sv @@
// Per-source connection rate limiter. A request can be taken in every cycle.
// Each request is registered, looked up with the RAM read, then evaluated into the result
// register; the result strobe is high for one cycle only.
// Throughput: one request per cycle; busy is never raised and results cannot be held off.
// Synchronous active-low reset empties the table and loads default settings.
// Depends on crl_pkg, crl_cam, crl_update and crl_ram.
`default_nettype none

module connection_rate_limiter (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           start,
    output logic                          busy,
    input  crl_pkg::t_req                 i_req,
    output logic                          o_result_valid,
    output crl_pkg::t_rsp                 o_rsp,
    input  wire                           i_cfg_we,
    input  wire [crl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [crl_pkg::CFG_W-1:0]      i_cfg_data
);
    import crl_pkg::*;

    t_cfg r_cfg;

    logic  r_s1_valid;
    t_req  r_s1_req;

    logic              r_s2_valid;
    t_lookup           r_s2_look;
    logic [TIME_W-1:0] r_s2_now;

    logic             r_fwd_valid;
    logic [IDX_W-1:0] r_fwd_idx;
    t_entry           r_fwd_entry;

    logic r_out_valid;
    t_rsp r_rsp;

    t_lookup            lookup;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry             cur_entry;
    logic               upd_we;
    logic               ram_we;
    t_entry             upd_entry;
    t_rsp               upd_rsp;

    assign busy = 1'b0;

    crl_cam u_cam (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_s1_valid),
        .i_addr   (r_s1_req.source_address),
        .o_lookup (lookup)
    );

    crl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s2_look.idx),
        .i_wdata (upd_entry),
        .i_raddr (lookup.idx),
        .o_rdata (ram_rdata)
    );

    // The write made in the cycle of this entry's read is not in the RAM data.
    assign cur_entry = (r_fwd_valid && (r_fwd_idx == r_s2_look.idx)) ? r_fwd_entry
                                                                    : t_entry'(ram_rdata);

    crl_update u_update (
        .i_kind  (r_s2_look.kind),
        .i_now   (r_s2_now),
        .i_entry (cur_entry),
        .i_cfg   (r_cfg),
        .o_we    (upd_we),
        .o_entry (upd_entry),
        .o_rsp   (upd_rsp)
    );

    assign ram_we = r_s2_valid && upd_we;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_ms      <= WINDOW_MS_RESET;
            r_cfg.max_per_window <= MAX_PER_WINDOW_RESET;
            r_cfg.block_ms       <= BLOCK_MS_RESET;
            r_s1_valid           <= 1'b0;
            r_s2_valid           <= 1'b0;
            r_fwd_valid          <= 1'b0;
            r_out_valid          <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_WINDOW_MS:      r_cfg.window_ms      <= i_cfg_data[15:0];
                    CFG_MAX_PER_WINDOW: r_cfg.max_per_window <= i_cfg_data[15:0];
                    CFG_BLOCK_MS:       r_cfg.block_ms       <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_s1_valid  <= start && !busy;
            r_s2_valid  <= r_s1_valid;
            r_fwd_valid <= ram_we;
            r_out_valid <= r_s2_valid;
        end
        r_s1_req    <= i_req;
        r_s2_look   <= lookup;
        r_s2_now    <= r_s1_req.now_ms;
        r_fwd_idx   <= r_s2_look.idx;
        r_fwd_entry <= upd_entry;
        r_rsp       <= upd_rsp;
    end

    assign o_result_valid = r_out_valid;
    assign o_rsp          = r_rsp;

endmodule

`default_nettype wire

@@ bench/connection_rate_limiter_tb.sv @@
// Self-checking testbench for connection_rate_limiter: directed and random requests,
// with every verdict predicted by a table model kept inside the bench.
// Depends on crl_pkg and the connection_rate_limiter RTL.

module connection_rate_limiter_tb;
    import crl_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int HOT_SOURCES = 16;

    typedef struct {
        t_req req;
        t_rsp rsp;
    } t_verdict_due;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_req                 i_req;
    logic                 o_result_valid;
    t_rsp                 o_rsp;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    // Model of the source table and the current settings.
    logic               slot_valid        [TABLE_ENTRIES];
    logic [ADDR_W-1:0]  slot_addr         [TABLE_ENTRIES];
    logic [TIME_W-1:0]  slot_window_start [TABLE_ENTRIES];
    logic [TIME_W-1:0]  slot_block_until  [TABLE_ENTRIES];
    logic [COUNT_W-1:0] slot_count        [TABLE_ENTRIES];
    logic [15:0]        cur_window_ms;
    logic [15:0]        cur_max_per_window;
    logic [19:0]        cur_block_ms;

    t_verdict_due       verdicts_due[$];
    logic [ADDR_W-1:0]  hot_source[HOT_SOURCES];
    logic [TIME_W-1:0]  wall_ms;
    int                 error_count;
    int                 checked_count;
    int                 sent_count;
    int                 calm_left;

    connection_rate_limiter i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req          (i_req),
        .o_result_valid (o_result_valid),
        .o_rsp          (o_rsp),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < 50) begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
        error_count++;
    endtask

    function automatic t_req attempt_of(input logic [ADDR_W-1:0] addr,
                                        input logic [TIME_W-1:0] now);
        t_req r;
        r.source_address = addr;
        r.now_ms = now;
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] fresh_address();
        logic [ADDR_W-1:0] a;
        do a = $urandom; while (a == '0);
        return a;
    endfunction

    function automatic int used_slots();
        int n;
        n = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot_valid[i]) n++;
        end
        return n;
    endfunction

    // Verdict for one request; updates the table model as the block would.
    function automatic t_rsp predict_verdict(input t_req r);
        t_rsp              rsp;
        int                hit;
        int                free_slot;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W:0]   block_end;
        logic [COUNT_W-1:0] sampled;
        rsp = '0;
        rsp.accepted = 1'b1;
        rsp.verdict_code = VC_KNOWN_OK;
        hit = -1;
        free_slot = -1;
        if (r.source_address == '0) begin
            rsp.accepted = 1'b0;
            rsp.verdict_code = VC_ZERO;
            return rsp;
        end
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot_valid[i]) begin
                if (hit < 0 && slot_addr[i] == r.source_address) hit = i;
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        if (hit < 0) begin
            rsp.verdict_code = VC_NEW;
            if (free_slot < 0) begin
                rsp.table_full = 1'b1;
            end else begin
                slot_valid[free_slot]        = 1'b1;
                slot_addr[free_slot]         = r.source_address;
                slot_window_start[free_slot] = r.now_ms;
                slot_block_until[free_slot]  = '0;
                slot_count[free_slot]        = COUNT_W'(1);
            end
            return rsp;
        end
        if (slot_count[hit] != '1) slot_count[hit]++;
        if (slot_block_until[hit] > r.now_ms) begin
            rsp.accepted = 1'b0;
            rsp.verdict_code = VC_BLOCKED;
            return rsp;
        end
        // Elapsed time wraps with the 48-bit millisecond clock.
        elapsed = r.now_ms - slot_window_start[hit];
        if (elapsed > cur_window_ms) begin
            sampled = slot_count[hit];
            slot_window_start[hit] = r.now_ms;
            slot_count[hit] = '0;
            slot_block_until[hit] = '0;
            if (sampled > cur_max_per_window) begin
                block_end = {1'b0, r.now_ms} + cur_block_ms;
                slot_block_until[hit] = block_end[TIME_W] ? '1 : block_end[TIME_W-1:0];
                rsp.accepted = 1'b0;
                rsp.verdict_code = VC_RATE;
            end
        end
        return rsp;
    endfunction

    task automatic send_attempt(input t_req r, input bit may_idle);
        int           gap;
        t_verdict_due due;
        gap = 0;
        if (may_idle) begin
            if (calm_left > 0) begin
                calm_left--;
            end else if ($urandom_range(0, 31) == 0) begin
                calm_left = $urandom_range(10, 40);
            end else begin
                gap = $urandom_range(0, 15);
            end
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy === 1'b1);
        due.req = r;
        due.rsp = predict_verdict(r);
        verdicts_due.push_back(due);
        sent_count++;
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (verdicts_due.size() != 0 && guard < 200) begin
            @(posedge i_clk);
            guard++;
        end
        if (verdicts_due.size() != 0) begin
            report_mismatch($sformatf("%0d requests never answered", verdicts_due.size()));
            verdicts_due.delete();
        end
    endtask

    // Writes all three registers back to back; the 16-bit ones get junk in the upper bits.
    task automatic apply_settings(input logic [15:0] window, input logic [15:0] max_attempts,
                                  input logic [19:0] block_len, input bit poke_unused);
        logic [19:0] noise;
        noise = 20'($urandom);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_WINDOW_MS;
        i_cfg_data  <= {noise[19:16], window};
        @(posedge i_clk);
        i_cfg_index <= CFG_MAX_PER_WINDOW;
        i_cfg_data  <= {noise[3:0], max_attempts};
        @(posedge i_clk);
        i_cfg_index <= CFG_BLOCK_MS;
        i_cfg_data  <= block_len;
        @(posedge i_clk);
        if (poke_unused) begin
            i_cfg_index <= CFG_UNUSED;
            i_cfg_data  <= noise;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cur_window_ms      = window;
        cur_max_per_window = max_attempts;
        cur_block_ms       = block_len;
    endtask

    task automatic test_reset_defaults();
        send_attempt(attempt_of('0, 48'd0), 1'b1);
        send_attempt(attempt_of(32'hFFFF_FFFF, 48'd0), 1'b1);
        repeat (10) send_attempt(attempt_of(32'hFFFF_FFFF, 48'd500), 1'b1);
        // Window has passed with twelve attempts counted, so the source gets blocked.
        send_attempt(attempt_of(32'hFFFF_FFFF, 48'd1001), 1'b1);
        send_attempt(attempt_of(32'hFFFF_FFFF, 48'd5000), 1'b1);
        send_attempt(attempt_of(32'hFFFF_FFFF, 48'd11001), 1'b1);
    endtask

    task automatic test_config_extremes();
        apply_settings(16'd0, 16'd0, 20'hFFFFF, 1'b0);
        // Block end saturates at the top of the time range.
        send_attempt(attempt_of(32'h0000_0001, 48'hFFFF_FFFF_FFF0), 1'b1);
        send_attempt(attempt_of(32'h0000_0001, 48'hFFFF_FFFF_FFF1), 1'b1);
        send_attempt(attempt_of(32'h0000_0001, 48'd5), 1'b1);
        send_attempt(attempt_of(32'h0000_0001, 48'hFFFF_FFFF_FFFF), 1'b1);
        apply_settings(16'hFFFF, 16'hFFFF, 20'd0, 1'b1);
        // Elapsed time across the clock wrap stays inside the window.
        send_attempt(attempt_of(32'h5A5A_A5A5, 48'hFFFF_FFFF_FFFF), 1'b1);
        send_attempt(attempt_of(32'h5A5A_A5A5, 48'd10), 1'b1);
        send_attempt(attempt_of('0, 48'hFFFF_FFFF_FFFF), 1'b1);
        send_attempt(attempt_of(32'h5A5A_A5A5, 48'd65535), 1'b1);
    endtask

    // A count equal to the limit passes, one above it blocks; elapsed equal to the
    // window does not end it, and the block ends exactly at its end time.
    task automatic test_limit_boundary();
        apply_settings(16'd100, 16'd5, 20'd50, 1'b0);
        send_attempt(attempt_of(32'h0F0F_F0F0, 48'h1234), 1'b0);
        repeat (3) send_attempt(attempt_of(32'h0F0F_F0F0, 48'h1234 + 48'd10), 1'b0);
        send_attempt(attempt_of(32'h0F0F_F0F0, 48'h1234 + 48'd101), 1'b0);
        repeat (4) send_attempt(attempt_of(32'h0F0F_F0F0, 48'h1234 + 48'd150), 1'b0);
        send_attempt(attempt_of(32'h0F0F_F0F0, 48'h1234 + 48'd201), 1'b1);
        send_attempt(attempt_of(32'h0F0F_F0F0, 48'h1234 + 48'd202), 1'b1);
        send_attempt(attempt_of(32'h0F0F_F0F0, 48'h1234 + 48'd251), 1'b1);
        send_attempt(attempt_of(32'h0F0F_F0F0, 48'h1234 + 48'd252), 1'b1);
    endtask

    // Mostly bursts from a few busy sources, mixed with zero addresses,
    // unseen sources and jumps of the clock in both directions.
    task automatic run_traffic(input int n_items, input bit allow_fill);
        int                sent;
        int                kind;
        int                len;
        logic [ADDR_W-1:0] addr;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 15);
            if (kind == 0) begin
                send_attempt(attempt_of('0, TIME_W'({$urandom, $urandom})), 1'b1);
                sent++;
            end else if (kind <= 2 && (allow_fill || used_slots() < TABLE_ENTRIES - 8)) begin
                send_attempt(attempt_of(fresh_address(), wall_ms), 1'b1);
                sent++;
            end else if (kind == 3) begin
                case ($urandom_range(0, 3))
                    0: wall_ms += TIME_W'($urandom_range(0, 500));
                    1: wall_ms += TIME_W'($urandom_range(0, 70000));
                    2: wall_ms += TIME_W'($urandom_range(0, 2000000));
                    default: wall_ms -= TIME_W'($urandom_range(0, 1000));
                endcase
            end else begin
                addr = hot_source[$urandom_range(0, HOT_SOURCES / 4 - 1)];
                if ($urandom_range(0, 3) == 0) addr = hot_source[$urandom_range(0, HOT_SOURCES - 1)];
                len = $urandom_range(1, 14);
                repeat (len) begin
                    wall_ms += TIME_W'($urandom_range(0, 2));
                    send_attempt(attempt_of(addr, wall_ms), 1'b1);
                    sent++;
                end
            end
        end
    endtask

    task automatic test_traffic_phases();
        apply_settings(16'($urandom_range(4, 40)), 16'($urandom_range(0, 6)),
                       20'($urandom_range(10, 400)), 1'b1);
        run_traffic(150, 1'b0);
        apply_settings(16'd0, 16'd0, 20'd0, 1'b0);
        run_traffic(100, 1'b0);
        apply_settings(16'hFFFF, 16'hFFFF, 20'hFFFFF, 1'b0);
        run_traffic(100, 1'b0);
        apply_settings(16'($urandom), 16'($urandom_range(0, 20)), 20'($urandom), 1'b0);
        run_traffic(100, 1'b0);
        apply_settings(16'($urandom_range(4, 40)), 16'($urandom_range(0, 6)),
                       20'($urandom_range(10, 400)), 1'b0);
        run_traffic(130, 1'b0);
    endtask

    task automatic test_table_full();
        while (used_slots() < TABLE_ENTRIES) begin
            wall_ms += TIME_W'($urandom_range(0, 3));
            send_attempt(attempt_of(fresh_address(), wall_ms), 1'b1);
        end
        run_traffic(120, 1'b1);
    endtask

    always @(posedge i_clk) begin : check_verdicts
        t_verdict_due due;
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1) begin
            if (verdicts_due.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                due = verdicts_due.pop_front();
                checked_count++;
                if (o_rsp.accepted !== due.rsp.accepted) begin
                    report_mismatch($sformatf("addr %h now %h: accepted %b, want %b",
                        due.req.source_address, due.req.now_ms, o_rsp.accepted,
                        due.rsp.accepted));
                end
                if (o_rsp.verdict_code !== due.rsp.verdict_code) begin
                    report_mismatch($sformatf("addr %h now %h: verdict %0d, want %0d",
                        due.req.source_address, due.req.now_ms, o_rsp.verdict_code,
                        due.rsp.verdict_code));
                end
                if (o_rsp.table_full !== due.rsp.table_full) begin
                    report_mismatch($sformatf("addr %h now %h: table_full %b, want %b",
                        due.req.source_address, due.req.now_ms, o_rsp.table_full,
                        due.rsp.table_full));
                end
            end
        end
    end

    initial begin
        start       <= 1'b0;
        i_req       <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;
        error_count   = 0;
        checked_count = 0;
        sent_count    = 0;
        calm_left     = 0;
        cur_window_ms      = WINDOW_MS_RESET;
        cur_max_per_window = MAX_PER_WINDOW_RESET;
        cur_block_ms       = BLOCK_MS_RESET;
        for (int i = 0; i < TABLE_ENTRIES; i++) slot_valid[i] = 1'b0;
        for (int i = 0; i < HOT_SOURCES; i++) hot_source[i] = fresh_address();
        wall_ms = TIME_W'({$urandom, $urandom});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_config_extremes();
        test_limit_boundary();
        test_traffic_phases();
        test_table_full();

        wait_drained();
        repeat (6) @(posedge i_clk);

        $display("Sent %0d requests and checked %0d verdicts, %0d mismatches.",
                 sent_count, checked_count, error_count);
        $display("Covered defaults, register extremes, limit edges, bursts and a full table.");
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/crl_pkg.sv
rtl/crl_ram.sv
rtl/crl_cam.sv
rtl/crl_update.sv
rtl/connection_rate_limiter.sv
bench/connection_rate_limiter_tb.sv
